[rtl/trapezoid_motion_profile_eval_defines.svh]
// Assertion macros shared by the motion profile evaluator modules.
`ifndef TRAPEZOID_MOTION_PROFILE_EVAL_DEFINES_SVH
`define TRAPEZOID_MOTION_PROFILE_EVAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TMP_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define TMP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define TMP_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define TMP_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

[rtl/tmp_pkg.sv]
// Shared constants and types of the motion profile evaluator.
package tmp_pkg;
   localparam int WORD_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int TIME_W     = WORD_W + FRAC_W + 2;
   localparam int U_W        = WORD_W - 1;
   localparam int VEL_W      = PROD_W - 1 - FRAC_W;
   localparam int VH_W       = VEL_W - WORD_W;
   localparam int REM_W      = WORD_W + 4;
   localparam int DIV_STEPS  = PROD_W;
   localparam int SQRT_STEPS = PROD_W / 2;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam logic [WORD_W-1:0] LIMIT_RESET = WORD_W'(1) << FRAC_W;

   typedef enum logic [1:0] {
      REG_START_POS = 2'd0,
      REG_END_POS   = 2'd1,
      REG_VEL_LIMIT = 2'd2,
      REG_ACC_LIMIT = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      KIND_START  = 3'd0,
      KIND_END    = 3'd1,
      KIND_ACCEL  = 3'd2,
      KIND_CRUISE = 3'd3,
      KIND_DECEL  = 3'd4
   } kind_type;

   typedef struct packed {
      logic              go;
      logic              op_sqrt;
      logic [PROD_W-1:0] num;
      logic [WORD_W:0]   den;
   } dsq_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] result;
   } dsq_rsp_type;

   typedef struct packed {
      logic              up;
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] vp;
      logic [TIME_W-1:0] ta;
      logic [TIME_W-1:0] tc;
      logic [TIME_W-1:0] tt;
   } prof_type;

   typedef struct packed {
      kind_type       kind;
      logic [U_W-1:0] u;
      logic [U_W-1:0] w;
   } item_type;
endpackage

[rtl/tmp_divsqrt.sv]
// Shared iterative unit: restoring divide (one bit a cycle) or square root.
`include "trapezoid_motion_profile_eval_defines.svh"
module tmp_divsqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  tmp_pkg::dsq_req_type req,
   output tmp_pkg::dsq_rsp_type rsp
);
   logic                         busy_ff, done_ff, op_ff;
   logic [tmp_pkg::CNT_W-1:0]    cnt_ff;
   logic [tmp_pkg::PROD_W-1:0]   num_ff, q_ff, num_in, q_in;
   logic [tmp_pkg::WORD_W:0]     den_ff;
   logic [tmp_pkg::REM_W-1:0]    rem_ff, rem_in, rem_sh, trial;
   logic                         fits, last;

   always_comb begin
      if (op_ff) begin
         rem_sh = {rem_ff[tmp_pkg::REM_W-3:0], num_ff[tmp_pkg::PROD_W-1 -: 2]};
         trial  = {q_ff[tmp_pkg::REM_W-3:0], 2'b01};
         num_in = num_ff << 2;
         last   = (cnt_ff == tmp_pkg::CNT_W'(tmp_pkg::SQRT_STEPS - 1));
      end else begin
         rem_sh = {rem_ff[tmp_pkg::REM_W-2:0], num_ff[tmp_pkg::PROD_W-1]};
         trial  = tmp_pkg::REM_W'(den_ff);
         num_in = num_ff << 1;
         last   = (cnt_ff == tmp_pkg::CNT_W'(tmp_pkg::DIV_STEPS - 1));
      end
      fits   = (rem_sh >= trial);
      rem_in = fits ? rem_sh - trial : rem_sh;
      q_in   = {q_ff[tmp_pkg::PROD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.go) begin
         op_ff  <= req.op_sqrt;
         cnt_ff <= '0;
         num_ff <= req.num;
         den_ff <= req.den;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         num_ff <= num_in;
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = q_ff;

   `TMP_ASSERT_NEXT(a_finish_flags_done, clock, reset, busy_ff && last && !req.go, done_ff && !busy_ff)
endmodule

[rtl/tmp_front.sv]
// Front part: solves the move profile after each configuration change and classifies samples.
module tmp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_change,
   input  logic [tmp_pkg::WORD_W-1:0]    start_pos,
   input  logic [tmp_pkg::WORD_W-1:0]    end_pos,
   input  logic [tmp_pkg::WORD_W-1:0]    vel_limit,
   input  logic [tmp_pkg::WORD_W-1:0]    acc_limit,
   input  logic [tmp_pkg::WORD_W-1:0]    sample_time,
   output logic                          ready,
   output tmp_pkg::prof_type             prof,
   output tmp_pkg::item_type             item
);
   typedef enum logic [3:0] {
      S_MUL, S_CLS, S_DA_GO, S_DA_WAIT, S_SQ_GO, S_SQ_WAIT,
      S_TA_GO, S_TA_WAIT, S_TC_GO, S_TC_WAIT, S_FIN, S_DONE
   } state_type;

   state_type                    state_ff;
   logic                         up_ff, tri_ff;
   logic [tmp_pkg::WORD_W-1:0]   v_ff, a_ff, d_ff, vp_ff, da2_ff;
   logic [tmp_pkg::PROD_W-1:0]   vv_ff, dxa_ff;
   logic [tmp_pkg::TIME_W-1:0]   ta_ff, tc_ff, tt_ff;
   logic [tmp_pkg::WORD_W-1:0]   v_n, a_n, d_c, rest;
   logic                         up_c;
   logic [tmp_pkg::PROD_W-1:0]   vv_c, dxa_c;
   tmp_pkg::dsq_req_type         dreq;
   tmp_pkg::dsq_rsp_type         drsp;
   logic [tmp_pkg::TIME_W-1:0]   t_ext, tac, r_c, w_c;
   logic                         neg;

   assign v_n   = (vel_limit == '0) ? tmp_pkg::WORD_W'(1) : vel_limit;
   assign a_n   = (acc_limit == '0) ? tmp_pkg::WORD_W'(1) : acc_limit;
   assign up_c  = ($signed(end_pos) > $signed(start_pos));
   assign d_c   = up_c ? end_pos - start_pos : start_pos - end_pos;
   assign vv_c  = v_n * v_n;
   assign dxa_c = d_c * a_n;
   // Twice the acceleration distance fits below the distance on a trapezoid.
   assign rest  = d_ff - {da2_ff[tmp_pkg::WORD_W-2:0], 1'b0};

   always_comb begin
      dreq.go      = 1'b0;
      dreq.op_sqrt = 1'b0;
      dreq.num     = '0;
      dreq.den     = '0;
      unique case (state_ff)
         S_DA_GO: begin
            dreq.go  = 1'b1;
            dreq.num = vv_ff;
            dreq.den = {a_ff, 1'b0};
         end
         S_SQ_GO: begin
            dreq.go      = 1'b1;
            dreq.op_sqrt = 1'b1;
            dreq.num     = dxa_ff;
         end
         S_TA_GO: begin
            dreq.go  = 1'b1;
            dreq.num = tmp_pkg::PROD_W'({vp_ff, tmp_pkg::FRAC_W'(0)});
            dreq.den = {1'b0, a_ff};
         end
         S_TC_GO: begin
            dreq.go  = 1'b1;
            dreq.num = tmp_pkg::PROD_W'({rest, tmp_pkg::FRAC_W'(0)});
            dreq.den = {1'b0, v_ff};
         end
         default: begin
         end
      endcase
   end

   tmp_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_ff @(posedge clock) begin
      if (reset || cfg_change) begin
         state_ff <= S_MUL;
      end else begin
         unique case (state_ff)
            S_MUL: begin
               v_ff     <= v_n;
               a_ff     <= a_n;
               d_ff     <= d_c;
               up_ff    <= up_c;
               vv_ff    <= vv_c;
               dxa_ff   <= dxa_c;
               state_ff <= S_CLS;
            end
            S_CLS: begin
               tri_ff <= (vv_ff > dxa_ff);
               if (vv_ff <= dxa_ff) begin
                  vp_ff    <= v_ff;
                  state_ff <= S_DA_GO;
               end else begin
                  tc_ff    <= '0;
                  state_ff <= S_SQ_GO;
               end
            end
            S_DA_GO: state_ff <= S_DA_WAIT;
            S_DA_WAIT: begin
               if (drsp.done) begin
                  da2_ff   <= drsp.result[tmp_pkg::WORD_W-1:0];
                  state_ff <= S_TA_GO;
               end
            end
            S_SQ_GO: state_ff <= S_SQ_WAIT;
            S_SQ_WAIT: begin
               if (drsp.done) begin
                  vp_ff    <= drsp.result[tmp_pkg::WORD_W-1:0];
                  state_ff <= S_TA_GO;
               end
            end
            S_TA_GO: state_ff <= S_TA_WAIT;
            S_TA_WAIT: begin
               if (drsp.done) begin
                  ta_ff    <= drsp.result[tmp_pkg::TIME_W-1:0];
                  state_ff <= tri_ff ? S_FIN : S_TC_GO;
               end
            end
            S_TC_GO: state_ff <= S_TC_WAIT;
            S_TC_WAIT: begin
               if (drsp.done) begin
                  tc_ff    <= drsp.result[tmp_pkg::TIME_W-1:0];
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               tt_ff    <= {ta_ff[tmp_pkg::TIME_W-2:0], 1'b0} + tc_ff;
               state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_DONE;
            default: state_ff <= S_MUL;
         endcase
      end
   end

   assign ready   = (state_ff == S_DONE);
   assign prof.up = up_ff;
   assign prof.d  = d_ff;
   assign prof.a  = a_ff;
   assign prof.vp = vp_ff;
   assign prof.ta = ta_ff;
   assign prof.tc = tc_ff;
   assign prof.tt = tt_ff;

   // Sample classification; the operands it picks stay below 2^31 in their phases.
   assign neg   = sample_time[tmp_pkg::WORD_W-1];
   assign t_ext = tmp_pkg::TIME_W'(sample_time);
   assign tac   = ta_ff + tc_ff;
   assign r_c   = tt_ff - t_ext;
   assign w_c   = t_ext - ta_ff;

   always_comb begin
      priority if (d_ff == '0 || neg) item.kind = tmp_pkg::KIND_START;
      else if (t_ext > tt_ff)         item.kind = tmp_pkg::KIND_END;
      else if (t_ext < ta_ff)         item.kind = tmp_pkg::KIND_ACCEL;
      else if (t_ext < tac)           item.kind = tmp_pkg::KIND_CRUISE;
      else                            item.kind = tmp_pkg::KIND_DECEL;
      unique case (item.kind)
         tmp_pkg::KIND_CRUISE: item.u = ta_ff[tmp_pkg::U_W-1:0];
         tmp_pkg::KIND_DECEL:  item.u = r_c[tmp_pkg::U_W-1:0];
         default:              item.u = sample_time[tmp_pkg::U_W-1:0];
      endcase
      item.w = w_c[tmp_pkg::U_W-1:0];
   end
endmodule

[rtl/tmp_fifo.sv]
// Two-entry queue between the classifying front and the evaluation pipeline.
`include "trapezoid_motion_profile_eval_defines.svh"
module tmp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tmp_pkg::item_type wdata,
   input  logic              pop,
   output tmp_pkg::item_type rdata,
   output logic              empty,
   output logic              full
);
   tmp_pkg::item_type mem_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wdata;
   end

   assign rdata = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

   `TMP_ASSERT_IMPLIES(a_no_overflow, clock, reset, full, !push)
   `TMP_ASSERT_IMPLIES(a_no_underflow, clock, reset, empty, !pop)
endmodule

[rtl/tmp_eval.sv]
// Back part: pipelined position evaluation for one classified sample per cycle.
`include "trapezoid_motion_profile_eval_defines.svh"
module tmp_eval (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  tmp_pkg::item_type           item,
   input  tmp_pkg::prof_type           prof,
   input  logic [tmp_pkg::WORD_W-1:0]  start_pos,
   input  logic [tmp_pkg::WORD_W-1:0]  end_pos,
   output logic                        out_valid,
   output logic [tmp_pkg::WORD_W-1:0]  out_position,
   output logic [tmp_pkg::WORD_W-1:0]  out_duration
);
   logic                           v1_ff, v2_ff, v3_ff, v4_ff, out_valid_ff;
   tmp_pkg::kind_type              k1_ff, k2_ff, k3_ff, k4_ff;
   logic [tmp_pkg::U_W-1:0]        u1_ff;
   logic [tmp_pkg::PROD_W-2:0]     m1_ff, m2_ff, plo_ff;
   logic [tmp_pkg::WORD_W-1:0]     phi_ff;
   logic [tmp_pkg::VEL_W-1:0]      cr2_ff, cr3_ff, h_ff, vel;
   logic [tmp_pkg::VEL_W:0]        xs_ff, xs_in;
   logic [tmp_pkg::PROD_W-1:0]     sum;
   logic [tmp_pkg::VEL_W+tmp_pkg::U_W-tmp_pkg::WORD_W-1:0] phi_full;
   logic [tmp_pkg::WORD_W-1:0]     xc, pos_in, position_ff, duration_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
   end

   assign vel      = m1_ff[tmp_pkg::PROD_W-2 -: tmp_pkg::VEL_W];
   assign phi_full = vel[tmp_pkg::VEL_W-1 -: tmp_pkg::VH_W] * u1_ff;
   // The square term wraps at the product word width.
   assign sum = {1'b0, plo_ff} + {phi_ff, tmp_pkg::WORD_W'(0)};

   always_comb begin
      unique case (k3_ff)
         tmp_pkg::KIND_ACCEL:  xs_in = {1'b0, h_ff};
         tmp_pkg::KIND_CRUISE: xs_in = {1'b0, h_ff} + {1'b0, cr3_ff};
         tmp_pkg::KIND_DECEL:  xs_in = (h_ff > tmp_pkg::VEL_W'(prof.d)) ? '0 :
                                       (tmp_pkg::VEL_W + 1)'(prof.d) - {1'b0, h_ff};
         default:              xs_in = '0;
      endcase
      xc = (xs_ff > (tmp_pkg::VEL_W + 1)'(prof.d)) ? prof.d : xs_ff[tmp_pkg::WORD_W-1:0];
      unique case (k4_ff)
         tmp_pkg::KIND_START: pos_in = start_pos;
         tmp_pkg::KIND_END:   pos_in = end_pos;
         default:             pos_in = prof.up ? start_pos + xc : start_pos - xc;
      endcase
   end

   always_ff @(posedge clock) begin
      k1_ff       <= item.kind;
      u1_ff       <= item.u;
      m1_ff       <= prof.a * item.u;
      m2_ff       <= prof.vp * item.w;
      k2_ff       <= k1_ff;
      plo_ff      <= vel[tmp_pkg::WORD_W-1:0] * u1_ff;
      phi_ff      <= phi_full[tmp_pkg::WORD_W-1:0];
      cr2_ff      <= m2_ff[tmp_pkg::PROD_W-2 -: tmp_pkg::VEL_W];
      k3_ff       <= k2_ff;
      h_ff        <= sum[tmp_pkg::PROD_W-1 -: tmp_pkg::VEL_W];
      cr3_ff      <= cr2_ff;
      k4_ff       <= k3_ff;
      xs_ff       <= xs_in;
      position_ff <= pos_in;
      duration_ff <= (|prof.tt[tmp_pkg::TIME_W-1:tmp_pkg::WORD_W]) ? '1 :
                     prof.tt[tmp_pkg::WORD_W-1:0];
   end

   assign out_valid    = out_valid_ff;
   assign out_position = position_ff;
   assign out_duration = duration_ff;

   `TMP_ASSERT_NEXT(a_pipe_delivers, clock, reset, v4_ff, out_valid_ff)
endmodule

[rtl/trapezoid_motion_profile_eval.sv]
// Top level of the trapezoidal motion profile evaluator.
// Usage:
//   Configuration: csr_we writes csr_wdata to register csr_index (0 start, 1 end,
//   2 velocity limit, 3 acceleration limit) at the clock edge, with no wait.
//   After reset and after every write the profile solver runs: a product step,
//   then one shared unit does the divides and, for a triangular move, the square
//   root, while busy stays high.
//   Requests: a sample beat is taken at an edge with start high and busy low.
//   Once the profile is solved, busy is low and one sample can be taken in
//   every cycle; the rate is set by the five-stage evaluation pipeline.
//   Results: rsp_strobe is high for one cycle with rsp_position and
//   rsp_move_duration, in the order the samples were taken.
//   The receiver cannot stall; every result is taken in its strobe cycle.
//   Reset restores start 0, end 0 and unit limits and clears all in-flight beats.
module trapezoid_motion_profile_eval (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [tmp_pkg::WORD_W-1:0]  req_sample_time,
   output logic                        rsp_strobe,
   output logic [tmp_pkg::WORD_W-1:0]  rsp_position,
   output logic [tmp_pkg::WORD_W-1:0]  rsp_move_duration,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [tmp_pkg::WORD_W-1:0]  csr_wdata
);
   logic [tmp_pkg::WORD_W-1:0] start_pos_ff, end_pos_ff, vel_limit_ff, acc_limit_ff;
   logic                       ready, fifo_empty, fifo_full, push;
   tmp_pkg::prof_type          prof;
   tmp_pkg::item_type          item_in, item_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff <= '0;
         end_pos_ff   <= '0;
         vel_limit_ff <= tmp_pkg::LIMIT_RESET;
         acc_limit_ff <= tmp_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (tmp_pkg::csr_reg_type'(csr_index))
            tmp_pkg::REG_START_POS: start_pos_ff <= csr_wdata;
            tmp_pkg::REG_END_POS:   end_pos_ff   <= csr_wdata;
            tmp_pkg::REG_VEL_LIMIT: vel_limit_ff <= csr_wdata;
            tmp_pkg::REG_ACC_LIMIT: acc_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign busy = !ready || fifo_full;
   assign push = start && !busy;

   tmp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg_change  (csr_we),
      .start_pos   (start_pos_ff),
      .end_pos     (end_pos_ff),
      .vel_limit   (vel_limit_ff),
      .acc_limit   (acc_limit_ff),
      .sample_time (req_sample_time),
      .ready       (ready),
      .prof        (prof),
      .item        (item_in)
   );

   tmp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (item_in),
      .pop   (!fifo_empty),
      .rdata (item_out),
      .empty (fifo_empty),
      .full  (fifo_full)
   );

   tmp_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (!fifo_empty),
      .item         (item_out),
      .prof         (prof),
      .start_pos    (start_pos_ff),
      .end_pos      (end_pos_ff),
      .out_valid    (rsp_strobe),
      .out_position (rsp_position),
      .out_duration (rsp_move_duration)
   );
endmodule

[tb/trapezoid_motion_profile_eval_test.sv]
// Self-checking testbench for the trapezoidal motion profile evaluator.
`timescale 1ns / 100ps

module trapezoid_motion_profile_eval_test;
   localparam longint unsigned WMASK = 64'hFFFF_FFFF;
   localparam longint unsigned WSIGN = 64'h8000_0000;
   localparam int DIRECTED_ROWS = 20;
   localparam int RANDOM_ITEMS = 1600;
   localparam longint CYCLE_LIMIT = 2_000_000;

   typedef struct {
      bit        do_cfg;
      logic [31:0] cfg_start;
      logic [31:0] cfg_end;
      logic [31:0] cfg_vel;
      logic [31:0] cfg_acc;
      logic [31:0] sample;
      bit        known;
      logic [31:0] exp_pos;
      logic [31:0] exp_dur;
   } stim_row_type;

   typedef struct {
      logic [31:0] position;
      logic [31:0] duration;
   } setpoint_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_sample_time = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_position;
   logic [31:0] rsp_move_duration;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = tmp_pkg::REG_START_POS;
   logic [31:0] csr_wdata = '0;

   // Model copy of the move registers.
   longint unsigned move_start, move_end, move_vel, move_acc;
   setpoint_type setpoint_queue[$];
   stim_row_type stim_table[DIRECTED_ROWS];
   int  mismatch_count = 0;
   longint cycle_count = 0;

   trapezoid_motion_profile_eval i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample_time(req_sample_time), .rsp_strobe(rsp_strobe),
      .rsp_position(rsp_position), .rsp_move_duration(rsp_move_duration),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic longint unsigned isqrt64(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned ramp_distance(longint unsigned a, longint unsigned t);
      longint unsigned vel;
      vel = (a * t) >> tmp_pkg::FRAC_W;
      return (vel * t) >> (tmp_pkg::FRAC_W + 1);
   endfunction

   function automatic setpoint_type profile_setpoint(logic [31:0] sample);
      setpoint_type sp;
      longint unsigned t, sb, eb, v, a, d, vp, ta, tc, tt, x, da, dec;
      bit up;
      t = sample;
      sb = move_start ^ WSIGN;
      eb = move_end ^ WSIGN;
      v = (move_vel != 0) ? move_vel : 1;
      a = (move_acc != 0) ? move_acc : 1;
      up = eb > sb;
      d = up ? eb - sb : sb - eb;
      if (d == 0) begin
         sp.position = move_start[31:0];
         sp.duration = '0;
         return sp;
      end
      if (v * v <= d * a) begin
         da = (v * v) / (2 * a);
         vp = v;
         ta = (v << tmp_pkg::FRAC_W) / a;
         tc = ((d - 2 * da) << tmp_pkg::FRAC_W) / v;
      end else begin
         vp = isqrt64(d * a);
         ta = (vp << tmp_pkg::FRAC_W) / a;
         tc = 0;
      end
      tt = 2 * ta + tc;
      sp.duration = (tt > WMASK) ? 32'hFFFF_FFFF : tt[31:0];
      if (t & WSIGN) begin
         sp.position = move_start[31:0];
         return sp;
      end
      if (t > tt) begin
         sp.position = move_end[31:0];
         return sp;
      end
      if (t < ta) x = ramp_distance(a, t);
      else if (t < ta + tc) x = ramp_distance(a, ta) + ((vp * (t - ta)) >> tmp_pkg::FRAC_W);
      else begin
         dec = ramp_distance(a, tt - t);
         x = (dec > d) ? 0 : d - dec;
      end
      if (x > d) x = d;
      sp.position = up ? 32'(move_start + x) : 32'(move_start - x);
      return sp;
   endfunction

   // Results are sampled at the edge that ends the strobe cycle.
   always @(posedge clock) begin
      setpoint_type sp;
      if (!reset && rsp_strobe) begin
         if (setpoint_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result beat %h %h",
               rsp_position, rsp_move_duration);
         end else begin
            sp = setpoint_queue.pop_front();
            if (rsp_position !== sp.position || rsp_move_duration !== sp.duration) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: position %h/%h duration %h/%h (expected/actual)",
                     sp.position, rsp_position, sp.duration, rsp_move_duration);
            end
         end
      end
   end

   task automatic write_register(tmp_pkg::csr_reg_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         tmp_pkg::REG_START_POS: move_start = value;
         tmp_pkg::REG_END_POS:   move_end = value;
         tmp_pkg::REG_VEL_LIMIT: move_vel = value;
         default:                move_acc = value;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits for all outstanding results, plus a margin for the pipeline.
   task automatic drain_results();
      while (setpoint_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic load_move(logic [31:0] s, logic [31:0] e, logic [31:0] v,
                            logic [31:0] a);
      drain_results();
      write_register(tmp_pkg::REG_START_POS, s);
      write_register(tmp_pkg::REG_END_POS, e);
      write_register(tmp_pkg::REG_VEL_LIMIT, v);
      write_register(tmp_pkg::REG_ACC_LIMIT, a);
   endtask

   // Drives one sample and returns after it is accepted; start stays high.
   task automatic send_sample(logic [31:0] sample, bit known, logic [31:0] pos,
                              logic [31:0] dur);
      setpoint_type sp;
      start <= 1'b1;
      req_sample_time <= sample;
      do @(posedge clock); while (busy);
      sp = profile_setpoint(sample);
      if (known) begin
         sp.position = pos;
         sp.duration = dur;
      end
      setpoint_queue.push_back(sp);
   endtask

   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_sample(setpoint_type ref_sp);
      logic [31:0] dur;
      dur = ref_sp.duration;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000 | $urandom();
         2: return dur + $urandom_range(0, 3);
         3: return dur - $urandom_range(0, 3);
         default: return (dur == 0) ? $urandom_range(0, 1000)
                                    : 32'({1'b0, 32'($urandom())} % ({1'b0, dur} + 33'd1));
      endcase
   endfunction

   function automatic logic [31:0] random_limit();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         default: return 32'($urandom_range(1, 64)) << $urandom_range(10, 20);
      endcase
   endfunction

   function automatic logic [31:0] random_position();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
      endcase
   endfunction

   initial begin
      setpoint_type probe;
      int burst;
      move_start = 0;
      move_end = 0;
      move_vel = 64'h1_0000;
      move_acc = 64'h1_0000;
      // Directed table: after reset, zero distance, long moves, saturation.
      stim_table[0] = '{0, 0, 0, 0, 0, 32'h0001_0000, 1, 32'h0, 32'h0};
      stim_table[1] = '{0, 0, 0, 0, 0, 32'h8000_0000, 1, 32'h0, 32'h0};
      stim_table[2] = '{1, 32'h0, 32'h000A_0000, 32'h0001_0000, 32'h0001_0000,
                        32'hFFFF_0000, 1, 32'h0, 32'h000B_0000};
      stim_table[3] = '{0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 32'h000A_0000, 32'h000B_0000};
      stim_table[4] = '{0, 0, 0, 0, 0, 32'h0, 0, 0, 0};
      stim_table[5] = '{0, 0, 0, 0, 0, 32'h0000_8000, 0, 0, 0};
      stim_table[6] = '{0, 0, 0, 0, 0, 32'h0005_8000, 0, 0, 0};
      stim_table[7] = '{0, 0, 0, 0, 0, 32'h000A_8000, 0, 0, 0};
      stim_table[8] = '{0, 0, 0, 0, 0, 32'h000B_0000, 1, 32'h000A_0000, 32'h000B_0000};
      stim_table[9] = '{1, 32'h0005_0000, 32'hFFFB_0000, 32'h0010_0000, 32'h0001_0000,
                        32'h0001_0000, 0, 0, 0};
      stim_table[10] = '{0, 0, 0, 0, 0, 32'h0003_0000, 0, 0, 0};
      stim_table[11] = '{1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001,
                         32'h0001_0000, 0, 0, 0};
      stim_table[12] = '{0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0};
      stim_table[13] = '{1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'h0000_0100, 0, 0, 0};
      stim_table[14] = '{0, 0, 0, 0, 0, 32'h0000_FFFF, 0, 0, 0};
      stim_table[15] = '{1, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0000_8000, 0, 0, 0};
      stim_table[16] = '{0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'h0, 0};
      stim_table[17] = '{1, 32'h1234_0000, 32'h1234_0000, 32'h0001_0000, 32'h0001_0000,
                         32'h0003_0000, 1, 32'h1234_0000, 32'h0};
      stim_table[18] = '{1, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                         32'h0000_0010, 0, 0, 0};
      stim_table[19] = '{0, 0, 0, 0, 0, 32'h5555_AAAA, 0, 0, 0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].do_cfg) begin
            idle_gap(1);
            load_move(stim_table[i].cfg_start, stim_table[i].cfg_end,
                      stim_table[i].cfg_vel, stim_table[i].cfg_acc);
         end
         if (stim_table[i].known && stim_table[i].sample == 32'hFFFF_FFFF)
            stim_table[i].exp_dur = profile_setpoint(0).duration;
         send_sample(stim_table[i].sample, stim_table[i].known,
                     stim_table[i].exp_pos, stim_table[i].exp_dur);
         idle_gap($urandom_range(0, 2));
      end

      // Random moves, each followed by a run of samples in bursts.
      for (int n = 0; n < RANDOM_ITEMS; ) begin
         idle_gap(1);
         load_move(random_position(), random_position(), random_limit(), random_limit());
         probe = profile_setpoint(0);
         for (int k = $urandom_range(10, 60); k > 0 && n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && k > 0; b++, k--, n++)
               send_sample(random_sample(probe), 0, 0, 0);
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         end
      end

      idle_gap(1);
      drain_results();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl
rtl/tmp_pkg.sv
rtl/tmp_divsqrt.sv
rtl/tmp_front.sv
rtl/tmp_fifo.sv
rtl/tmp_eval.sv
rtl/trapezoid_motion_profile_eval.sv
tb/trapezoid_motion_profile_eval_test.sv
